>>> rtl/bbmt_pkg.sv
// bbmt_pkg: shared type for the bang-bang minimum-time unit.
// No dependencies.
`timescale 1ns / 1ps

package bbmt_pkg;

  // per-cell handshake control: incoming valid and stage advance
  typedef struct packed {
    logic vld;
    logic adv;
  } bbmt_ctl_t;

endpackage

>>> rtl/bbmt_front.sv
// bbmt_front: three-stage front end, differences, squares and radicands.
// Depends on bbmt_pkg.
`timescale 1ns / 1ps

module bbmt_front import bbmt_pkg::*; #(
  parameter int WORD_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        vld_i,
  input  logic [2:0]                  en_i,
  output logic [2:0]                  vld_o,
  input  logic [WORD_BITS-2:0]        accel_i,
  input  logic signed [WORD_BITS-1:0] start_pos,
  input  logic signed [WORD_BITS-1:0] start_vel,
  input  logic signed [WORD_BITS-1:0] goal_pos,
  input  logic signed [WORD_BITS-1:0] goal_vel,
  output logic                        qneg0_o,
  output logic [2*WORD_BITS+1:0]      rad0_o,
  output logic                        qneg1_o,
  output logic [2*WORD_BITS+1:0]      rad1_o,
  output logic signed [WORD_BITS:0]   sumv_o,
  output logic [WORD_BITS:0]          absdv_o
);

  localparam int W  = WORD_BITS;
  localparam int QW = 2 * W + 3;
  localparam int UQ = 2 * W + 2;

  logic [2:0] vld_r;

  logic signed [W-1:0]   v1_r, v2_r;
  logic signed [W:0]     dx_r, sumv0_r;
  logic [W:0]            absdv0_r;
  logic signed [W:0]     dv;

  logic signed [2*W-1:0] m1_r, m2_r;
  logic signed [2*W:0]   ad_r;
  logic signed [W:0]     sumv1_r;
  logic [W:0]            absdv1_r;

  logic signed [QW-1:0]  sqx, adx, q0, q1;
  logic                  qneg0_r, qneg1_r;
  logic [UQ-1:0]         rad0_r, rad1_r;
  logic signed [W:0]     sumv2_r;
  logic [W:0]            absdv2_r;

  assign dv = (W+1)'(goal_vel) - (W+1)'(start_vel);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en_i[0]) vld_r[0] <= vld_i;
      if (en_i[1]) vld_r[1] <= vld_r[0];
      if (en_i[2]) vld_r[2] <= vld_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en_i[0]) begin
      v1_r     <= start_vel;
      v2_r     <= goal_vel;
      dx_r     <= (W+1)'(goal_pos) - (W+1)'(start_pos);
      sumv0_r  <= (W+1)'(start_vel) + (W+1)'(goal_vel);
      absdv0_r <= dv[W] ? (W+1)'(-dv) : (W+1)'(dv);
    end
  end

  always_ff @(posedge clk) begin
    if (en_i[1]) begin
      m1_r     <= v1_r * v1_r;
      m2_r     <= v2_r * v2_r;
      ad_r     <= $signed({1'b0, accel_i}) * dx_r;
      sumv1_r  <= sumv0_r;
      absdv1_r <= absdv0_r;
    end
  end

  assign sqx = QW'(m1_r) + QW'(m2_r);
  assign adx = QW'(ad_r);
  assign q0  = (sqx <<< 1) + (adx <<< 2);
  assign q1  = (sqx <<< 1) - (adx <<< 2);

  always_ff @(posedge clk) begin
    if (en_i[2]) begin
      qneg0_r  <= q0[QW-1];
      rad0_r   <= q0[UQ-1:0];
      qneg1_r  <= q1[QW-1];
      rad1_r   <= q1[UQ-1:0];
      sumv2_r  <= sumv1_r;
      absdv2_r <= absdv1_r;
    end
  end

  assign vld_o   = vld_r;
  assign qneg0_o = qneg0_r;
  assign rad0_o  = rad0_r;
  assign qneg1_o = qneg1_r;
  assign rad1_o  = rad1_r;
  assign sumv_o  = sumv2_r;
  assign absdv_o = absdv2_r;

endmodule

>>> rtl/bbmt_sqrt_cell.sv
// bbmt_sqrt_cell: one root bit of two square roots, digit by digit.
// Depends on bbmt_pkg.
`timescale 1ns / 1ps

module bbmt_sqrt_cell import bbmt_pkg::*; #(
  parameter int WORD_BITS = 32,
  parameter int SIDE_W    = 68
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  bbmt_ctl_t              ctl_i,
  output logic                   vld_o,
  input  logic [2*WORD_BITS+1:0] rad0_i,
  input  logic [WORD_BITS+3:0]   rem0_i,
  input  logic [WORD_BITS:0]     root0_i,
  input  logic [2*WORD_BITS+1:0] rad1_i,
  input  logic [WORD_BITS+3:0]   rem1_i,
  input  logic [WORD_BITS:0]     root1_i,
  input  logic [SIDE_W-1:0]      side_i,
  output logic [2*WORD_BITS+1:0] rad0_o,
  output logic [WORD_BITS+3:0]   rem0_o,
  output logic [WORD_BITS:0]     root0_o,
  output logic [2*WORD_BITS+1:0] rad1_o,
  output logic [WORD_BITS+3:0]   rem1_o,
  output logic [WORD_BITS:0]     root1_o,
  output logic [SIDE_W-1:0]      side_o
);

  localparam int UQ  = 2 * WORD_BITS + 2;
  localparam int RW  = WORD_BITS + 1;
  localparam int RMW = WORD_BITS + 4;

  logic           vld_r;
  logic [UQ-1:0]  rad0_r, rad1_r;
  logic [RMW-1:0] rem0_r, rem1_r;
  logic [RW-1:0]  root0_r, root1_r;
  logic [SIDE_W-1:0] side_r;

  logic [RMW-1:0] rem2_0, rem2_1, trial0, trial1;
  logic           ge0, ge1;

  assign rem2_0 = {rem0_i[RMW-3:0], rad0_i[UQ-1:UQ-2]};
  assign rem2_1 = {rem1_i[RMW-3:0], rad1_i[UQ-1:UQ-2]};
  assign trial0 = {1'b0, root0_i, 2'b01};
  assign trial1 = {1'b0, root1_i, 2'b01};
  assign ge0    = rem2_0 >= trial0;
  assign ge1    = rem2_1 >= trial1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctl_i.adv) begin
      vld_r <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.adv) begin
      rad0_r  <= rad0_i << 2;
      rad1_r  <= rad1_i << 2;
      rem0_r  <= ge0 ? rem2_0 - trial0 : rem2_0;
      rem1_r  <= ge1 ? rem2_1 - trial1 : rem2_1;
      root0_r <= {root0_i[RW-2:0], ge0};
      root1_r <= {root1_i[RW-2:0], ge1};
      side_r  <= side_i;
    end
  end

  assign vld_o   = vld_r;
  assign rad0_o  = rad0_r;
  assign rad1_o  = rad1_r;
  assign rem0_o  = rem0_r;
  assign rem1_o  = rem1_r;
  assign root0_o = root0_r;
  assign root1_o = root1_r;
  assign side_o  = side_r;

endmodule

>>> rtl/bbmt_select.sv
// bbmt_select: two stages forming the four candidates and keeping the least valid.
// Depends on bbmt_pkg.
`timescale 1ns / 1ps

module bbmt_select import bbmt_pkg::*; #(
  parameter int WORD_BITS = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      vld_i,
  input  logic [1:0]                en_i,
  output logic [1:0]                vld_o,
  input  logic [WORD_BITS-2:0]      accel_i,
  input  logic [WORD_BITS:0]        r0_i,
  input  logic [WORD_BITS:0]        r1_i,
  input  logic                      qneg0_i,
  input  logic                      qneg1_i,
  input  logic signed [WORD_BITS:0] sumv_i,
  input  logic [WORD_BITS:0]        absdv_i,
  output logic [WORD_BITS+1:0]      u_o,
  output logic                      found_o
);

  localparam int W  = WORD_BITS;
  localparam int CW = W + 3;
  localparam int UW = W + 2;

  logic [1:0] vld_r;
  logic signed [CW-1:0] b0, b1, rx0, rx1, absx;
  logic signed [CW-1:0] c [4];
  logic [3:0]    ok;
  logic [UW-1:0] cu_r [4];
  logic [3:0]    ok_r;
  logic [UW-1:0] ua, ub, u_r;
  logic          fa, fb, found_r;

  assign b1   = CW'(sumv_i);
  assign b0   = -b1;
  assign rx0  = $signed({2'b00, r0_i});
  assign rx1  = $signed({2'b00, r1_i});
  assign absx = $signed({2'b00, absdv_i});
  assign c[0] = b0 + rx0;
  assign c[1] = b0 - rx0;
  assign c[2] = b1 + rx1;
  assign c[3] = b1 - rx1;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ok[i] = (c[i] >= absx) && (accel_i != '0) && !((i < 2) ? qneg0_i : qneg1_i);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en_i[0]) vld_r[0] <= vld_i;
      if (en_i[1]) vld_r[1] <= vld_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en_i[0]) begin
      for (int i = 0; i < 4; i++) cu_r[i] <= c[i][UW-1:0];
      ok_r <= ok;
    end
  end

  always_comb begin
    fa = ok_r[0] | ok_r[1];
    ua = (ok_r[0] && (!ok_r[1] || cu_r[0] < cu_r[1])) ? cu_r[0] : cu_r[1];
    fb = ok_r[2] | ok_r[3];
    ub = (ok_r[2] && (!ok_r[3] || cu_r[2] < cu_r[3])) ? cu_r[2] : cu_r[3];
  end

  always_ff @(posedge clk) begin
    if (en_i[1]) begin
      found_r <= fa | fb;
      u_r     <= (fa && (!fb || ua < ub)) ? ua : ub;
    end
  end

  assign vld_o   = vld_r;
  assign u_o     = u_r;
  assign found_o = found_r;

endmodule

>>> rtl/bbmt_div_cell.sv
// bbmt_div_cell: one quotient bit of the time division, with saturation tracking.
// Depends on bbmt_pkg.
`timescale 1ns / 1ps

module bbmt_div_cell import bbmt_pkg::*; #(
  parameter int WORD_BITS = 32,
  parameter int NUM_BITS  = 50
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bbmt_ctl_t            ctl_i,
  output logic                 vld_o,
  input  logic [WORD_BITS-2:0] accel_i,
  input  logic [NUM_BITS-1:0]  num_i,
  input  logic [WORD_BITS-1:0] rem_i,
  input  logic [WORD_BITS-1:0] quo_i,
  input  logic                 sat_i,
  input  logic                 found_i,
  output logic [NUM_BITS-1:0]  num_o,
  output logic [WORD_BITS-1:0] rem_o,
  output logic [WORD_BITS-1:0] quo_o,
  output logic                 sat_o,
  output logic                 found_o
);

  localparam int W = WORD_BITS;

  logic                vld_r;
  logic [NUM_BITS-1:0] num_r;
  logic [W-1:0]        rem_r, quo_r, rem2, den;
  logic                sat_r, found_r, ge;

  assign rem2 = {rem_i[W-2:0], num_i[NUM_BITS-1]};
  assign den  = {1'b0, accel_i};
  assign ge   = rem2 >= den;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (ctl_i.adv) begin
      vld_r <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.adv) begin
      num_r   <= num_i << 1;
      rem_r   <= ge ? rem2 - den : rem2;
      quo_r   <= {quo_i[W-2:0], ge};
      sat_r   <= sat_i | quo_i[W-1];
      found_r <= found_i;
    end
  end

  assign vld_o   = vld_r;
  assign num_o   = num_r;
  assign rem_o   = rem_r;
  assign quo_o   = quo_r;
  assign sat_o   = sat_r;
  assign found_o = found_r;

endmodule

>>> rtl/bang_bang_min_time_unit.sv
// bang_bang_min_time_unit: top level, minimum bang-bang move time on one axis.
// Depends on bbmt_pkg, bbmt_front, bbmt_sqrt_cell, bbmt_select, bbmt_div_cell.
//
//   channel  dir  fields (low bit up)                           handshake
//   in_      in   tdata: start_pos, start_vel, goal_pos, goal_vel  tvalid/tready
//   out_     out  tdata: min_time; tuser: no_solution            tvalid/tready
//   cfg_     in   wdata: max_accel                               wen
//
// One request per cycle sustained while the output is accepted. The pipeline is a
// front end, the square-root row (one root bit per cell), the select stages and the
// divider row (one quotient bit per cell). Every stage has its own valid bit and
// advances when it is empty or the next stage advances, so bubbles collapse and
// a stalled output still lets requests fill the row. Reset clears all valid bits.
`timescale 1ns / 1ps

module bang_bang_min_time_unit import bbmt_pkg::*; #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // start_pos, start_vel, goal_pos, goal_vel
  input  logic [((4*WORD_BITS+7)/8)*8-1:0]       in_tdata,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // min_time
  output logic [((WORD_BITS+7)/8)*8-1:0]         out_tdata,
  // no_solution
  output logic [0:0]                             out_tuser,
  input  logic                                   cfg_wen,
  input  logic [WORD_BITS-2:0]                   cfg_wdata
);

  localparam int W      = WORD_BITS;
  localparam int UQ     = 2 * W + 2;
  localparam int RW     = W + 1;
  localparam int RMW    = W + 4;
  localparam int NS     = W + 1;
  localparam int UW     = W + 2;
  localparam int NB     = UW + FRAC_BITS;
  localparam int SIDE_W = 2 * W + 4;
  localparam int S_SQ   = 3;
  localparam int S_SEL  = S_SQ + NS;
  localparam int S_DIV  = S_SEL + 2;
  localparam int NST    = S_DIV + NB;
  localparam int OUT_TW = ((W + 7) / 8) * 8;

  logic [W-2:0] max_accel_r;
  logic [NST:0] en;
  logic [NST-1:0] vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_accel_r <= (W-1)'(1) << FRAC_BITS;
    end else if (cfg_wen) begin
      max_accel_r <= cfg_wdata;
    end
  end

  always_comb begin
    en[NST] = out_tready;
    for (int i = NST - 1; i >= 0; i--) en[i] = !vld[i] || en[i+1];
  end
  assign in_tready = en[0];

  logic          qneg0, qneg1;
  logic [UQ-1:0] rad0, rad1;
  logic signed [W:0] sumv;
  logic [W:0]    absdv;

  bbmt_front #(.WORD_BITS(W)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .vld_i    (in_tvalid),
    .en_i     (en[2:0]),
    .vld_o    (vld[2:0]),
    .accel_i  (max_accel_r),
    .start_pos(in_tdata[W-1:0]),
    .start_vel(in_tdata[2*W-1:W]),
    .goal_pos (in_tdata[3*W-1:2*W]),
    .goal_vel (in_tdata[4*W-1:3*W]),
    .qneg0_o  (qneg0),
    .rad0_o   (rad0),
    .qneg1_o  (qneg1),
    .rad1_o   (rad1),
    .sumv_o   (sumv),
    .absdv_o  (absdv)
  );

  logic [UQ-1:0]     sq_rad0  [NS+1];
  logic [UQ-1:0]     sq_rad1  [NS+1];
  logic [RMW-1:0]    sq_rem0  [NS+1];
  logic [RMW-1:0]    sq_rem1  [NS+1];
  logic [RW-1:0]     sq_root0 [NS+1];
  logic [RW-1:0]     sq_root1 [NS+1];
  logic [SIDE_W-1:0] sq_side  [NS+1];

  assign sq_rad0[0]  = rad0;
  assign sq_rad1[0]  = rad1;
  assign sq_rem0[0]  = '0;
  assign sq_rem1[0]  = '0;
  assign sq_root0[0] = '0;
  assign sq_root1[0] = '0;
  assign sq_side[0]  = {qneg1, qneg0, absdv, sumv};

  for (genvar g = 0; g < NS; g++) begin : g_sqrt
    bbmt_ctl_t ctl;
    assign ctl.vld = vld[S_SQ+g-1];
    assign ctl.adv = en[S_SQ+g];
    bbmt_sqrt_cell #(.WORD_BITS(W), .SIDE_W(SIDE_W)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl_i  (ctl),
      .vld_o  (vld[S_SQ+g]),
      .rad0_i (sq_rad0[g]),
      .rem0_i (sq_rem0[g]),
      .root0_i(sq_root0[g]),
      .rad1_i (sq_rad1[g]),
      .rem1_i (sq_rem1[g]),
      .root1_i(sq_root1[g]),
      .side_i (sq_side[g]),
      .rad0_o (sq_rad0[g+1]),
      .rem0_o (sq_rem0[g+1]),
      .root0_o(sq_root0[g+1]),
      .rad1_o (sq_rad1[g+1]),
      .rem1_o (sq_rem1[g+1]),
      .root1_o(sq_root1[g+1]),
      .side_o (sq_side[g+1])
    );
  end

  logic [UW-1:0] u;
  logic          found;

  bbmt_select #(.WORD_BITS(W)) u_select (
    .clk     (clk),
    .rst_n   (rst_n),
    .vld_i   (vld[S_SEL-1]),
    .en_i    (en[S_SEL+1:S_SEL]),
    .vld_o   (vld[S_SEL+1:S_SEL]),
    .accel_i (max_accel_r),
    .r0_i    (sq_root0[NS]),
    .r1_i    (sq_root1[NS]),
    .qneg0_i (sq_side[NS][2*W+2]),
    .qneg1_i (sq_side[NS][2*W+3]),
    .sumv_i  (sq_side[NS][W:0]),
    .absdv_i (sq_side[NS][2*W+1:W+1]),
    .u_o     (u),
    .found_o (found)
  );

  logic [NB-1:0] dv_num   [NB+1];
  logic [W-1:0]  dv_rem   [NB+1];
  logic [W-1:0]  dv_quo   [NB+1];
  logic          dv_sat   [NB+1];
  logic          dv_found [NB+1];

  assign dv_num[0]   = {u, {FRAC_BITS{1'b0}}};
  assign dv_rem[0]   = '0;
  assign dv_quo[0]   = '0;
  assign dv_sat[0]   = 1'b0;
  assign dv_found[0] = found;

  for (genvar g = 0; g < NB; g++) begin : g_div
    bbmt_ctl_t ctl;
    assign ctl.vld = vld[S_DIV+g-1];
    assign ctl.adv = en[S_DIV+g];
    bbmt_div_cell #(.WORD_BITS(W), .NUM_BITS(NB)) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl_i  (ctl),
      .vld_o  (vld[S_DIV+g]),
      .accel_i(max_accel_r),
      .num_i  (dv_num[g]),
      .rem_i  (dv_rem[g]),
      .quo_i  (dv_quo[g]),
      .sat_i  (dv_sat[g]),
      .found_i(dv_found[g]),
      .num_o  (dv_num[g+1]),
      .rem_o  (dv_rem[g+1]),
      .quo_o  (dv_quo[g+1]),
      .sat_o  (dv_sat[g+1]),
      .found_o(dv_found[g+1])
    );
  end

  logic [W-1:0] min_time;

  assign min_time   = !dv_found[NB] ? '0 : (dv_sat[NB] ? '1 : dv_quo[NB]);
  assign out_tvalid = vld[NST-1];
  assign out_tdata  = OUT_TW'(min_time);
  assign out_tuser  = !dv_found[NB];

endmodule

>>> rtl/bbmt_checker.sv
// bbmt_checker: port-level checks for bang_bang_min_time_unit, bound to the top level.
// Depends on bang_bang_min_time_unit.
`timescale 1ns / 1ps

module bbmt_checker #(
  parameter int OUT_TW = 32
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_TW-1:0] out_tdata,
  input logic [0:0]        out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_no_sol_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("no_solution with nonzero time");

  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output drains");

endmodule

bind bang_bang_min_time_unit bbmt_checker #(.OUT_TW(OUT_TW)) u_bbmt_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);

>>> tb/bang_bang_min_time_unit_tb.sv
// Testbench for bang_bang_min_time_unit: directed table then random move requests,
// checked against an in-bench predictor of the minimum bang-bang move time.
// Depends on the RTL top level only.
`timescale 1ns / 1ps

module bang_bang_min_time_unit_tb;

  localparam int WB = 32;
  localparam int FB = 16;
  localparam int LATENCY = 2 * WB + FB + 8;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct {
    logic [WB-1:0] min_time;
    logic          no_solution;
  } move_time_t;

  typedef struct {
    logic [WB-1:0] p1, v1, p2, v2;
    bit            typed;
    logic [WB-1:0] min_time;
    logic          no_solution;
  } move_row_t;

  logic            clk;
  logic            rst_n;
  logic            in_tvalid;
  logic            in_tready;
  logic [4*WB-1:0] in_tdata;
  logic            out_tvalid;
  logic            out_tready;
  logic [WB-1:0]   out_tdata;
  logic [0:0]      out_tuser;
  logic            cfg_wen;
  logic [WB-2:0]   cfg_wdata;

  bang_bang_min_time_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
  );

  move_time_t     pending_times[$];
  logic [WB-2:0]  accel_limit;
  int             mismatches;
  longint         cycles;
  bit             hold_req;
  int             hold_left;
  int             rx_mode;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic logic signed [127:0] root_floor(input logic signed [127:0] q);
    logic signed [127:0] r, c;
    r = 0;
    for (int i = 63; i >= 0; i--) begin
      c = r | (128'sd1 <<< i);
      if (c * c <= q) r = c;
    end
    return r;
  endfunction

  function automatic move_time_t move_time(input logic signed [WB-1:0] p1, v1, p2, v2,
                                           input logic [WB-2:0] acc);
    logic signed [127:0] w1, w2, wp1, wp2, wa, sq, ad, q, base, r, cand, best, absdv;
    logic [127:0] quo;
    bit found;
    move_time_t res;
    w1 = v1; w2 = v2; wp1 = p1; wp2 = p2;
    wa = {97'b0, acc};
    absdv = (w2 > w1) ? w2 - w1 : w1 - w2;
    found = 0;
    best = 0;
    if (acc != 0) begin
      sq = 2 * (w1 * w1 + w2 * w2);
      ad = 4 * wa * (wp2 - wp1);
      for (int k = 0; k < 2; k++) begin
        q = (k == 0) ? sq + ad : sq - ad;
        base = (k == 0) ? -(w1 + w2) : w1 + w2;
        if (q >= 0) begin
          r = root_floor(q);
          for (int j = 0; j < 2; j++) begin
            cand = (j == 0) ? base + r : base - r;
            if (cand >= absdv && (!found || cand < best)) begin
              best = cand;
              found = 1;
            end
          end
        end
      end
    end
    if (found) begin
      quo = (best <<< FB) / wa;
      res.min_time = (quo > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : quo[WB-1:0];
      res.no_solution = 1'b0;
    end else begin
      res.min_time = '0;
      res.no_solution = 1'b1;
    end
    return res;
  endfunction

  task automatic send_move(input move_row_t row);
    move_time_t e;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= {row.v2, row.p2, row.v1, row.p1};
    do @(posedge clk); while (!in_tready);
    e = move_time(row.p1, row.v1, row.p2, row.v2, accel_limit);
    if (row.typed && (e.min_time !== row.min_time || e.no_solution !== row.no_solution))
      $display("table row disagrees with predictor: %h/%b vs %h/%b",
               row.min_time, row.no_solution, e.min_time, e.no_solution);
    if (row.typed) begin
      e.min_time = row.min_time;
      e.no_solution = row.no_solution;
    end
    pending_times.insert(pending_times.size(), e);
  endtask

  task automatic sender_gap();
    int g;
    g = $urandom_range(1, 6);
    @(negedge clk);
    in_tvalid <= 1'b0;
    repeat (g - 1) @(negedge clk);
  endtask

  task automatic write_accel(input logic [WB-2:0] value);
    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (pending_times.size() == 0);
    repeat (LATENCY + 10) @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wen <= 1'b0;
    accel_limit = value;
  endtask

  function automatic logic [WB-1:0] pick_field();
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom;
      3: return ($urandom_range(0, 1) != 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      4: return $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
      default: return 32'($urandom_range(0, 32'h001F_FFFF)) - 32'h0010_0000;
    endcase
  endfunction

  task automatic random_moves(input int count);
    move_row_t row;
    int burst;
    burst = 0;
    for (int n = 0; n < count; n++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 24);
        if ($urandom_range(0, 2) != 0) sender_gap();
      end
      burst--;
      row.p1 = pick_field();
      row.v1 = pick_field();
      row.p2 = pick_field();
      row.v2 = pick_field();
      row.typed = 0;
      send_move(row);
    end
  endtask

  // receiver: long hold-off on request, else a mode-driven stall pattern
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_req) begin
      hold_req <= 1'b0;
      hold_left <= 400;
      out_tready <= 1'b0;
    end else begin
      if (cycles % 64 == 0) rx_mode <= $urandom_range(0, 3);
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= $urandom_range(0, 1);
        2: out_tready <= ($urandom_range(0, 9) != 0);
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    move_time_t e;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_times.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h/%b", out_tdata, out_tuser);
      end else begin
        e = pending_times.pop_front();
        if (out_tdata !== e.min_time || out_tuser[0] !== e.no_solution) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: min_time exp %h got %h, no_solution exp %b got %b",
                     e.min_time, out_tdata, e.no_solution, out_tuser[0]);
        end
      end
    end
  end

  move_row_t moves[] = '{
    '{32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 32'h0, 1'b0},
    '{32'h0, 32'h0, 32'h0001_0000, 32'h0, 1'b1, 32'h0002_0000, 1'b0},
    '{32'h0001_0000, 32'h0, 32'h0, 32'h0, 1'b1, 32'h0002_0000, 1'b0},
    '{32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h0, 1'b0, 32'h0, 1'b0},
    '{32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h0, 1'b0, 32'h0, 1'b0},
    '{32'h0, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 1'b0, 32'h0, 1'b0},
    '{32'h0, 32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
    '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, 32'h0, 1'b0},
    '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0, 1'b0},
    '{32'h0, 32'h0001_0000, 32'h0, 32'h0001_0000, 1'b0, 32'h0, 1'b0},
    '{32'h0, 32'h0001_0000, 32'h0, 32'hFFFF_0000, 1'b0, 32'h0, 1'b0},
    '{32'h0, 32'h0002_0000, 32'h0001_0000, 32'h0, 1'b0, 32'h0, 1'b0},
    '{32'h0005_0000, 32'hFFFD_0000, 32'hFFFE_8000, 32'h0001_4000, 1'b0, 32'h0, 1'b0}
  };

  initial begin
    logic [WB-2:0] accel_plan[6];
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_wen = 1'b0;
    cfg_wdata = '0;
    out_tready = 1'b0;
    hold_req = 0;
    hold_left = 0;
    rx_mode = 0;
    cycles = 0;
    mismatches = 0;
    accel_limit = 31'd65536;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (moves[i]) send_move(moves[i]);
    random_moves(150);
    hold_req = 1;
    random_moves(200);

    accel_plan = '{31'd1, 31'h7FFF_FFFF, 31'd0, 31'($urandom), 31'd2048, 31'd65536};
    foreach (accel_plan[i]) begin
      write_accel(accel_plan[i]);
      foreach (moves[j]) begin
        move_row_t row;
        row = moves[j];
        row.typed = 0;
        send_move(row);
      end
      random_moves(i == 2 ? 50 : 160);
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (pending_times.size() == 0);
    repeat (LATENCY + 20) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/bbmt_pkg.sv
rtl/bbmt_front.sv
rtl/bbmt_sqrt_cell.sv
rtl/bbmt_select.sv
rtl/bbmt_div_cell.sv
rtl/bang_bang_min_time_unit.sv
rtl/bbmt_checker.sv
tb/bang_bang_min_time_unit_tb.sv
